@@ src/adcfcc_pkg.sv @@
// ----------------------------------------------------------------------------
// adcfcc_pkg
// Shared types and constants of the channel-ID checker: register map, word
// kind codes, limits and ID constants.
// ----------------------------------------------------------------------------
`default_nettype none

package adcfcc_pkg;

  // limits
  localparam int unsigned MAX_SAMPLE_WORDS_DEF = 256;
  localparam int unsigned MAX_DATA_BANKS       = 4;

  // configuration port
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // register indexes (word address = index)
  localparam logic [2:0] REG_SITE_NUMBER       = 3'd0;
  localparam logic [2:0] REG_DATA_BANK_COUNT   = 3'd1;
  localparam logic [2:0] REG_BANK_LETTERS      = 3'd2;
  localparam logic [2:0] REG_SCRATCHPAD_ENABLE = 3'd3;
  localparam logic [2:0] REG_NARROW_ID_MASK    = 3'd4;
  localparam logic [2:0] REG_SEGMENT_OFFSET    = 3'd5;
  localparam logic [2:0] REG_SAMPLE_WORD_COUNT = 3'd6;

  // register reset values
  localparam logic [2:0] SITE_NUMBER_RST       = 3'd0;
  localparam logic [2:0] DATA_BANK_COUNT_RST   = 3'd4;
  localparam logic [7:0] BANK_LETTERS_RST      = 8'd228;
  localparam logic [7:0] SEGMENT_OFFSET_RST    = 8'd0;
  localparam logic [8:0] SAMPLE_WORD_COUNT_RST = 9'd32;

  // channel ID constants
  localparam logic [7:0] WIDE_MASK     = 8'hff;
  localparam logic [7:0] NARROW_MASK   = 8'h1f;
  localparam logic [4:0] UPPER_BASE    = 5'd28;
  localparam logic [5:0] SCRATCH_WORDS = 6'd8;

  // classification of one beat
  typedef enum logic [1:0] {
    KIND_OUTSIDE   = 2'd0,
    KIND_ID        = 2'd1,
    KIND_SEQUENCE  = 2'd2,
    KIND_UNCHECKED = 2'd3
  } word_kind_t;

endpackage : adcfcc_pkg

`default_nettype wire

@@ src/adc_frame_channel_id_checker_unit.sv @@
// result: registered, valid in the cycle after its frame beat is accepted
// throughput: one beat per cycle; a new beat is taken while a result waits,
//   as long as the result register is empty or being drained that cycle
// reset: synchronous active-high rst clears the sample position, error flag,
//   sequence count and result valid, and loads register defaults
// ----------------------------------------------------------------------------
// adc_frame_channel_id_checker_unit
// Walks the words of an interleaved sample, checks the channel IDs of one
// site's segment and the scratchpad sequence word, and flags each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_frame_channel_id_checker_unit #(
  parameter int unsigned MAX_SAMPLE_WORDS = adcfcc_pkg::MAX_SAMPLE_WORDS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [adcfcc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [adcfcc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [adcfcc_pkg::PDATA_W-1:0]  prdata,
  output logic                                 pready,
  // frame channel
  input  wire logic                            frame_valid,
  output logic                                 frame_ready,
  input  wire logic [31:0]                     frame_word,
  // result channel
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output logic      [1:0]                      word_kind,
  output logic                                 word_error,
  output logic                                 end_of_sample,
  output logic                                 sample_ok,
  output logic      [31:0]                     sequence_count
);

  import adcfcc_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_SAMPLE_WORDS);
  localparam int unsigned CMP_W = (POS_W > 9) ? POS_W + 1 : 10;

  // configuration registers
  logic [2:0] site_number;
  logic [2:0] data_bank_count;
  logic [7:0] bank_letters;
  logic       scratchpad_enable;
  logic       narrow_id_mask;
  logic [7:0] segment_offset;
  logic [8:0] sample_word_count;

  // running state
  logic [POS_W-1:0] word_position;
  logic             error_seen;
  logic [31:0]      expected_count;

  logic [POS_W-1:0] word_position_next;
  logic             error_seen_next;
  logic [31:0]      expected_count_next;

  // datapath
  logic             wr_en;
  logic [2:0]       reg_idx;
  logic             take;
  logic [2:0]       banks;
  logic [5:0]       ndata;
  logic [5:0]       seglen;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] off_ext;
  logic [CMP_W-1:0] rel;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] wps;
  logic             in_seg;
  logic [4:0]       chan;
  logic [2:0]       bank_pos;
  logic [3:0]       two_n_m1;
  logic [2:0]       mirror_pos;
  logic [1:0]       letter;
  logic [3:0]       letter_base;
  logic [4:0]       code;
  logic [7:0]       id_exp;
  logic [7:0]       id_mask;
  logic [31:0]      count_inc;
  word_kind_t       kind;
  logic             err;
  logic             eos;
  logic             ok;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      site_number       <= SITE_NUMBER_RST;
      data_bank_count   <= DATA_BANK_COUNT_RST;
      bank_letters      <= BANK_LETTERS_RST;
      scratchpad_enable <= 1'b0;
      narrow_id_mask    <= 1'b0;
      segment_offset    <= SEGMENT_OFFSET_RST;
      sample_word_count <= SAMPLE_WORD_COUNT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SITE_NUMBER:       site_number       <= pwdata[2:0];
        REG_DATA_BANK_COUNT:   data_bank_count   <= pwdata[2:0];
        REG_BANK_LETTERS:      bank_letters      <= pwdata[7:0];
        REG_SCRATCHPAD_ENABLE: scratchpad_enable <= pwdata[0];
        REG_NARROW_ID_MASK:    narrow_id_mask    <= pwdata[0];
        REG_SEGMENT_OFFSET:    segment_offset    <= pwdata[7:0];
        REG_SAMPLE_WORD_COUNT: sample_word_count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SITE_NUMBER:       prdata = PDATA_W'(site_number);
      REG_DATA_BANK_COUNT:   prdata = PDATA_W'(data_bank_count);
      REG_BANK_LETTERS:      prdata = PDATA_W'(bank_letters);
      REG_SCRATCHPAD_ENABLE: prdata = PDATA_W'(scratchpad_enable);
      REG_NARROW_ID_MASK:    prdata = PDATA_W'(narrow_id_mask);
      REG_SEGMENT_OFFSET:    prdata = PDATA_W'(segment_offset);
      REG_SAMPLE_WORD_COUNT: prdata = PDATA_W'(sample_word_count);
      default:               prdata = '0;
    endcase
  end

  // handshake: result register drains or is empty
  assign frame_ready = !result_valid || result_ready;
  assign take        = frame_valid && frame_ready;

  // effective bank count and segment geometry
  always_comb begin
    if (data_bank_count == 3'd0) begin
      banks = 3'd1;
    end else if (data_bank_count > 3'(MAX_DATA_BANKS)) begin
      banks = 3'(MAX_DATA_BANKS);
    end else begin
      banks = data_bank_count;
    end
    ndata  = {banks, 3'b000};
    seglen = ndata + (scratchpad_enable ? SCRATCH_WORDS : 6'd0);
  end

  // effective sample length and end of sample
  always_comb begin
    cnt_ext = CMP_W'(sample_word_count);
    if (sample_word_count == 9'd0) begin
      wps = CMP_W'(1);
    end else if (cnt_ext > CMP_W'(MAX_SAMPLE_WORDS)) begin
      wps = CMP_W'(MAX_SAMPLE_WORDS);
    end else begin
      wps = cnt_ext;
    end
    pos_ext = CMP_W'(word_position);
    eos     = (pos_ext >= wps - CMP_W'(1));
  end

  // segment position
  assign off_ext = CMP_W'(segment_offset);
  assign rel     = pos_ext - off_ext;
  assign in_seg  = (pos_ext >= off_ext) && (rel < CMP_W'(seglen));
  assign chan    = rel[4:0];

  // expected channel ID, bank order mirrored in the upper half
  always_comb begin
    bank_pos    = chan[4:2];
    two_n_m1    = {banks, 1'b0} - 4'd1;
    mirror_pos  = (bank_pos < banks) ? bank_pos : 3'(two_n_m1 - {1'b0, bank_pos});
    letter      = 2'(bank_letters >> {mirror_pos[1:0], 1'b0});
    letter_base = {letter, 2'b00};
    if (chan < {banks, 2'b00}) begin
      code = 5'(letter_base) + 5'(chan[1:0]);
    end else begin
      code = UPPER_BASE - 5'(letter_base) + 5'(chan[1:0]);
    end
    id_exp  = {site_number, code};
    id_mask = narrow_id_mask ? NARROW_MASK : WIDE_MASK;
  end

  // classify and check this beat
  assign count_inc = expected_count + 32'd1;

  always_comb begin
    kind                = KIND_OUTSIDE;
    err                 = 1'b0;
    expected_count_next = expected_count;
    if (in_seg) begin
      if (rel < CMP_W'(ndata)) begin
        kind = KIND_ID;
        err  = ((frame_word[7:0] & id_mask) != (id_exp & id_mask));
      end else if (rel == CMP_W'(ndata)) begin
        kind = KIND_SEQUENCE;
        if (frame_word == count_inc) begin
          expected_count_next = count_inc;
        end else begin
          err = 1'b1;
        end
      end else begin
        kind = KIND_UNCHECKED;
      end
    end
    ok = eos && !(error_seen || err);
    if (eos) begin
      error_seen_next    = 1'b0;
      word_position_next = '0;
    end else begin
      error_seen_next    = error_seen || err;
      word_position_next = POS_W'(pos_ext + CMP_W'(1));
    end
  end

  // sample state
  always_ff @(posedge clk) begin
    if (rst) begin
      word_position  <= '0;
      error_seen     <= 1'b0;
      expected_count <= '0;
    end else if (take) begin
      word_position  <= word_position_next;
      error_seen     <= error_seen_next;
      expected_count <= expected_count_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      word_kind      <= kind;
      word_error     <= err;
      end_of_sample  <= eos;
      sample_ok      <= ok;
      sequence_count <= expected_count_next;
    end
  end

endmodule : adc_frame_channel_id_checker_unit

`default_nettype wire

@@ src/adcfcc_checker.sv @@
// ----------------------------------------------------------------------------
// adcfcc_checker
// Port-level assertions for the channel-ID checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module adcfcc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        frame_ready,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [1:0]  word_kind,
  input wire logic        word_error,
  input wire logic        end_of_sample,
  input wire logic        sample_ok,
  input wire logic [31:0] sequence_count
);

  import adcfcc_pkg::*;

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // an empty result register never holds off the frame side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> frame_ready)
    else $error("frame not ready while result register empty");

  // pass flag only on the last word of a sample
  a_ok_at_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && sample_ok |-> end_of_sample)
    else $error("sample_ok outside end of sample");

  // only checked words can fail
  a_error_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && word_error |->
      (word_kind == KIND_ID) || (word_kind == KIND_SEQUENCE))
    else $error("error flagged on an unchecked word");

  // stalled result beat holds its count
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(sequence_count))
    else $error("stalled result beat changed");

endmodule : adcfcc_checker

bind adc_frame_channel_id_checker_unit adcfcc_checker u_adcfcc_checker (
  .clk            (clk),
  .rst            (rst),
  .frame_ready    (frame_ready),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .word_kind      (word_kind),
  .word_error     (word_error),
  .end_of_sample  (end_of_sample),
  .sample_ok      (sample_ok),
  .sequence_count (sequence_count)
);

`default_nettype wire
